// File: src/cad_pkg.sv
package cad_pkg;

  // Counter width of the detect window and hold-off timers (8 to 32).
  localparam int TIMER_BITS = 16;
  localparam logic [32:0] TMR_MAX = (33'd1 << TIMER_BITS) - 33'd1;

  // Item function codes
  localparam logic [2:0] FUNC_TICK        = 3'd0;
  localparam logic [2:0] FUNC_PIN_EDGE    = 3'd1;
  localparam logic [2:0] FUNC_WLS_CONNECT = 3'd2;
  localparam logic [2:0] FUNC_WRD_CONNECT = 3'd3;
  localparam logic [2:0] FUNC_WRD_DISCON  = 3'd4;
  localparam logic [2:0] FUNC_WLS_DISCON  = 3'd5;
  localparam logic [2:0] FUNC_USER_WAKE   = 3'd6;

  // Configuration register indexes
  localparam logic [2:0] REG_DETECT_WINDOW = 3'd0;
  localparam logic [2:0] REG_HOLDOFF       = 3'd1;
  localparam logic [2:0] REG_VRECT_LOW     = 3'd2;
  localparam logic [2:0] REG_VRECT_HIGH    = 3'd3;
  localparam logic [2:0] REG_PIN_SETTLE    = 3'd4;

  typedef struct packed {
    logic [2:0]  func;
    logic [15:0] vrect_mv;
    logic        tx_open;
    logic        pin_level;
  } item_t;

  typedef struct packed {
    logic aligned;
    logic edge_armed;
    logic status_notify;
  } result_t;

  typedef struct packed {
    logic [15:0] detect_window_ms;
    logic [15:0] disconnect_holdoff_ms;
    logic [15:0] vrect_low_mv;
    logic [15:0] vrect_high_mv;
    logic [7:0]  pin_settle_ms;
  } cfg_t;

  // Timer load: zero counts as one tick, saturate at the counter maximum.
  function automatic logic [TIMER_BITS-1:0] timer_load(input logic [15:0] v);
    logic [32:0] wide;
    wide = {17'd0, v};
    if (wide == 33'd0) begin
      wide = 33'd1;
    end
    if (wide > TMR_MAX) begin
      wide = TMR_MAX;
    end
    return wide[TIMER_BITS-1:0];
  endfunction

endpackage

// File: src/charger_alignment_detector_unit.sv
// Channel | Signals                                        | Dir | Accepted when
// --------+------------------------------------------------+-----+------------------------
// in      | in_valid, in_ready, func, vrect_mv, tx_open,   | in  | in_valid & in_ready
//         | pin_level                                      |     |
// out     | out_valid, out_ready, aligned, edge_armed,     | out | out_valid & out_ready
//         | status_notify                                  |     |
// cfg     | cfg_we, cfg_index, cfg_data                    | in  | cfg_we
//
// Flow: an input beat lands in the input register, is processed once the output
//   register is free or draining, and its result is then registered in the output register.
//   Throughput is one beat per cycle while out_ready does not hold the output.
// Reset: rst is synchronous and active high; it restores the register defaults,
//   arms edge detection, sets aligned and idles all three timers.
// Stalls: while a result waits on out_ready, one more beat is taken into the
//   input register; in_ready drops only when both registers are full.
module charger_alignment_detector_unit
  import cad_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // input beats
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  func,
  input  logic [15:0] vrect_mv,
  input  logic        tx_open,
  input  logic        pin_level,
  // result beats
  output logic        out_valid,
  input  logic        out_ready,
  output logic        aligned,
  output logic        edge_armed,
  output logic        status_notify,
  // configuration writes
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t    cfg;
  item_t   in_buf;
  logic    in_full;
  logic    proc;
  result_t res_next;
  result_t res;

  // Item is processed when the input register holds one and the output
  // register is free or being drained this cycle.
  assign proc     = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || proc;

  // configuration registers; writes to unused indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.detect_window_ms      <= 16'd1500;
      cfg.disconnect_holdoff_ms <= 16'd2500;
      cfg.vrect_low_mv          <= 16'd3500;
      cfg.vrect_high_mv         <= 16'd4500;
      cfg.pin_settle_ms         <= 8'd50;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DETECT_WINDOW: cfg.detect_window_ms      <= cfg_data;
        REG_HOLDOFF:       cfg.disconnect_holdoff_ms <= cfg_data;
        REG_VRECT_LOW:     cfg.vrect_low_mv          <= cfg_data;
        REG_VRECT_HIGH:    cfg.vrect_high_mv         <= cfg_data;
        REG_PIN_SETTLE:    cfg.pin_settle_ms         <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_buf.func      <= func;
      in_buf.vrect_mv  <= vrect_mv;
      in_buf.tx_open   <= tx_open;
      in_buf.pin_level <= pin_level;
    end
  end

  // state machine proper: flags, timers and the alignment decision
  cad_core u_core (
    .clk    (clk),
    .rst    (rst),
    .proc   (proc),
    .item   (in_buf),
    .cfg    (cfg),
    .result (res_next)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      res <= res_next;
    end
  end

  assign aligned       = res.aligned;
  assign edge_armed    = res.edge_armed;
  assign status_notify = res.status_notify;

`ifndef ASSERT_OFF
  a_proc_gives_result: assert property (@(posedge clk) disable iff (rst)
    proc |=> out_valid)
    else $error("processed beat produced no result");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> in_full && out_valid && !out_ready)
    else $error("input stalled without a full pipeline");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    in_full && !proc |=> in_full)
    else $error("pending beat lost");
`endif

endmodule

// File: src/cad_core.sv
module cad_core
  import cad_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    proc,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t result
);

  logic                  armed, armed_next;
  logic                  wls_active, wls_active_next;
  logic                  wrd_active, wrd_active_next;
  logic                  aligned, aligned_next;
  logic                  pin_latched, pin_latched_next;
  logic [7:0]            settle_left, settle_left_next;
  logic [TIMER_BITS-1:0] detect_left, detect_left_next;
  logic [TIMER_BITS-1:0] holdoff_left, holdoff_left_next;
  logic                  notify;
  logic                  settle_exp, detect_exp, hold_exp;

  always_comb begin
    armed_next        = armed;
    wls_active_next   = wls_active;
    wrd_active_next   = wrd_active;
    aligned_next      = aligned;
    pin_latched_next  = pin_latched;
    settle_left_next  = settle_left;
    detect_left_next  = detect_left;
    holdoff_left_next = holdoff_left;
    notify            = 1'b0;
    settle_exp        = 1'b0;
    detect_exp        = 1'b0;
    hold_exp          = 1'b0;

    case (item.func)
      FUNC_TICK: begin
        if (settle_left != 8'd0) begin
          settle_left_next = settle_left - 8'd1;
          settle_exp       = (settle_left == 8'd1);
        end
        if (detect_left != '0) begin
          detect_left_next = detect_left - 1'b1;
          detect_exp       = (detect_left == TIMER_BITS'(1));
        end
        if (holdoff_left != '0) begin
          holdoff_left_next = holdoff_left - 1'b1;
          hold_exp          = (holdoff_left == TIMER_BITS'(1));
        end
        if (settle_exp) begin
          pin_latched_next = item.pin_level;
        end
        // hysteresis decision; pin latched this same tick counts
        if (detect_exp) begin
          if (item.vrect_mv < cfg.vrect_low_mv && !pin_latched_next && !item.tx_open) begin
            armed_next   = 1'b0;
            aligned_next = 1'b0;
            notify       = 1'b1;
          end else if (item.vrect_mv > cfg.vrect_high_mv || item.tx_open) begin
            aligned_next = 1'b1;
            notify       = 1'b1;
            if (!wls_active && !wrd_active) begin
              armed_next = 1'b1;
            end
          end
        end
        if (hold_exp && !wls_active && !wrd_active) begin
          armed_next = 1'b1;
        end
      end
      FUNC_PIN_EDGE: begin
        if (armed) begin
          armed_next = 1'b0;
          if (!item.tx_open) begin
            detect_left_next = timer_load(cfg.detect_window_ms);
            settle_left_next = (cfg.pin_settle_ms == 8'd0) ? 8'd1 : cfg.pin_settle_ms;
          end
        end
      end
      FUNC_WLS_CONNECT: begin
        wls_active_next   = 1'b1;
        armed_next        = 1'b0;
        detect_left_next  = '0;
        holdoff_left_next = '0;
        aligned_next      = 1'b1;
        notify            = 1'b1;
      end
      FUNC_WRD_CONNECT: begin
        wrd_active_next  = 1'b1;
        armed_next       = 1'b0;
        detect_left_next = '0;
        aligned_next     = 1'b1;
        notify           = 1'b1;
      end
      FUNC_WRD_DISCON: begin
        wrd_active_next = 1'b0;
        if (!wls_active) begin
          armed_next = 1'b1;
        end
        aligned_next = 1'b1;
        notify       = 1'b1;
      end
      FUNC_WLS_DISCON: begin
        wls_active_next   = 1'b0;
        armed_next        = 1'b0;
        detect_left_next  = '0;
        holdoff_left_next = timer_load(cfg.disconnect_holdoff_ms);
        aligned_next      = 1'b1;
        notify            = 1'b1;
      end
      FUNC_USER_WAKE: begin
        if (!wls_active && !wrd_active) begin
          aligned_next = 1'b1;
          armed_next   = 1'b1;
          notify       = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed        <= 1'b1;
      wls_active   <= 1'b0;
      wrd_active   <= 1'b0;
      aligned      <= 1'b1;
      pin_latched  <= 1'b0;
      settle_left  <= 8'd0;
      detect_left  <= '0;
      holdoff_left <= '0;
    end else if (proc) begin
      armed        <= armed_next;
      wls_active   <= wls_active_next;
      wrd_active   <= wrd_active_next;
      aligned      <= aligned_next;
      pin_latched  <= pin_latched_next;
      settle_left  <= settle_left_next;
      detect_left  <= detect_left_next;
      holdoff_left <= holdoff_left_next;
    end
  end

  assign result.aligned       = aligned_next;
  assign result.edge_armed    = armed_next;
  assign result.status_notify = notify;

`ifndef ASSERT_OFF
  a_edge_starts: assert property (@(posedge clk) disable iff (rst)
    proc && item.func == FUNC_PIN_EDGE && armed && !item.tx_open
    |=> !armed && detect_left != '0 && settle_left != 8'd0)
    else $error("accepted pin edge did not start timers");

  a_wls_connect: assert property (@(posedge clk) disable iff (rst)
    proc && item.func == FUNC_WLS_CONNECT
    |=> wls_active && !armed && aligned && detect_left == '0 && holdoff_left == '0)
    else $error("wireless connect left stale state");

  a_hold_state: assert property (@(posedge clk) disable iff (rst)
    !proc |=> $stable(armed) && $stable(aligned) && $stable(detect_left)
              && $stable(settle_left) && $stable(holdoff_left))
    else $error("state changed without a beat");
`endif

endmodule
